// ----- rtl/core/escape_run_length_codec_defines.svh -----
// Assertion macros used by the escape run-length codec command queue.
`ifndef ESCAPE_RUN_LENGTH_CODEC_DEFINES_SVH
`define ESCAPE_RUN_LENGTH_CODEC_DEFINES_SVH
`ifndef SYNTHESIS
`define ERLC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ERLC_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ERLC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ERLC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- rtl/core/erlc_pkg.sv -----
// Types, codes and helpers of the escape run-length codec.
package erlc_pkg;

    localparam int RUN_BITS   = 21;
    localparam int LIMIT_BITS = 24;
    localparam int CFG_DW     = 24;

    localparam logic [RUN_BITS-1:0] RUN_MAX = '1;

    localparam logic [1:0] STREAM_CHAR = 2'd0;
    localparam logic [1:0] STREAM_RUN  = 2'd1;
    localparam logic [1:0] STREAM_DATA = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LIMIT = 2'd1;
    localparam logic [1:0] ST_ORDER = 2'd2;
    localparam logic [1:0] ST_TRUNC = 2'd3;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_ESC   = 2'd1;
    localparam logic [1:0] REG_LIMIT = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_sel;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [7:0]          out_byte;
        logic [1:0]          out_stream;
        logic [RUN_BITS-1:0] repeat_res;
        logic [1:0]          status;
        logic                end_mark;
    } out_word_t;

    typedef struct packed {
        logic                  decode_mode;
        logic [7:0]            escape_code;
        logic [LIMIT_BITS-1:0] decoded_limit;
    } cfg_t;

    // one unit of work for the back end: a run to expand or a finished word
    typedef struct packed {
        logic                valid;
        logic                is_run;
        logic [7:0]          byte_val;
        logic [1:0]          stream;
        logic [RUN_BITS-1:0] rep;
        logic [1:0]          status;
    } unit_t;

    typedef struct packed {
        unit_t a;
        unit_t b;
        logic  last;
    } cmd_t;

    function automatic unit_t make_run(input logic [7:0] c, input logic [RUN_BITS-1:0] r);
        unit_t u;
        u.valid    = 1'b1;
        u.is_run   = 1'b1;
        u.byte_val = c;
        u.stream   = STREAM_CHAR;
        u.rep      = r;
        u.status   = ST_OK;
        return u;
    endfunction

    function automatic unit_t make_word(input logic [7:0] c, input logic [RUN_BITS-1:0] r,
                                        input logic [1:0] st);
        unit_t u;
        u.valid    = 1'b1;
        u.is_run   = 1'b0;
        u.byte_val = c;
        u.stream   = STREAM_DATA;
        u.rep      = r;
        u.status   = st;
        return u;
    endfunction

endpackage

// ----- rtl/core/erlc_front.sv -----
// Front end: run grouping for encode, stream parsing and limit check for decode.
module erlc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  erlc_pkg::cfg_t    cfg,
    input  erlc_pkg::in_word_t word,
    input  logic              accept,
    output erlc_pkg::cmd_t    cmd,
    output logic              cmd_push
);
    import erlc_pkg::*;

    localparam logic [1:0] PH_CHAR  = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_BYTE  = 2'd2;

    logic [7:0]            run_char_reg, run_char_next;
    logic [RUN_BITS-1:0]   run_count_reg, run_count_next;
    logic [RUN_BITS-1:0]   varint_acc_reg, varint_acc_next;
    logic [1:0]            phase_reg, phase_next;
    logic [LIMIT_BITS-1:0] produced_reg, produced_next;

    unit_t                 ua, ub;
    logic                  del_en;
    logic [7:0]            del_byte;
    logic [RUN_BITS-1:0]   del_rep;
    logic [LIMIT_BITS:0]   sum;
    logic [RUN_BITS-1:0]   acc_new;

    always_comb
    begin
        run_char_next   = run_char_reg;
        run_count_next  = run_count_reg;
        varint_acc_next = varint_acc_reg;
        phase_next      = phase_reg;
        produced_next   = produced_reg;
        ua              = '0;
        ub              = '0;
        del_en          = 1'b0;
        del_byte        = word.in_byte;
        del_rep         = RUN_BITS'(1);
        sum             = '0;
        acc_new         = '0;
        if (!cfg.decode_mode)
        begin
            if (run_count_reg != '0 && word.in_byte == run_char_reg && run_count_reg != RUN_MAX)
            begin
                run_count_next = run_count_reg + RUN_BITS'(1);
            end
            else
            begin
                if (run_count_reg != '0)
                begin
                    ua = make_run(run_char_reg, run_count_reg);
                end
                run_char_next  = word.in_byte;
                run_count_next = RUN_BITS'(1);
            end
            if (word.last)
            begin
                ub             = make_run(run_char_next, run_count_next);
                run_count_next = '0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_COUNT:
                begin
                    if (!word.stream_sel)
                    begin
                        ua = make_word(8'd0, '0, ST_ORDER);
                    end
                    else
                    begin
                        if (varint_acc_reg > (RUN_MAX >> 7))
                            acc_new = RUN_MAX;
                        else
                            acc_new = {varint_acc_reg[RUN_BITS-8:0], word.in_byte[6:0]};
                        varint_acc_next = acc_new;
                        if (!word.in_byte[7])
                        begin
                            if (acc_new == RUN_BITS'(1))
                            begin
                                del_en          = 1'b1;
                                del_byte        = cfg.escape_code;
                                varint_acc_next = '0;
                                phase_next      = PH_CHAR;
                            end
                            else
                            begin
                                phase_next = PH_BYTE;
                            end
                        end
                    end
                end
                PH_BYTE:
                begin
                    if (word.stream_sel)
                    begin
                        ua = make_word(8'd0, '0, ST_ORDER);
                    end
                    else
                    begin
                        del_en          = (varint_acc_reg != '0);
                        del_rep         = varint_acc_reg;
                        varint_acc_next = '0;
                        phase_next      = PH_CHAR;
                    end
                end
                default:
                begin
                    if (word.stream_sel)
                    begin
                        ua = make_word(8'd0, '0, ST_ORDER);
                    end
                    else if (word.in_byte == cfg.escape_code)
                    begin
                        varint_acc_next = '0;
                        phase_next      = PH_COUNT;
                    end
                    else
                    begin
                        del_en = 1'b1;
                    end
                end
            endcase
            if (del_en)
            begin
                sum = {1'b0, produced_reg} + (LIMIT_BITS+1)'(del_rep);
                if (sum > {1'b0, cfg.decoded_limit})
                begin
                    ua = make_word(del_byte, '0, ST_LIMIT);
                end
                else
                begin
                    ua            = make_word(del_byte, del_rep, ST_OK);
                    produced_next = sum[LIMIT_BITS-1:0];
                end
            end
            if (word.last)
            begin
                if (phase_next != PH_CHAR)
                    ub = make_word(8'd0, '0, ST_TRUNC);
                phase_next      = PH_CHAR;
                varint_acc_next = '0;
                produced_next   = '0;
            end
        end
        // keep the first slot filled
        if (!ua.valid)
        begin
            ua = ub;
            ub = '0;
        end
        cmd.a    = ua;
        cmd.b    = ub;
        cmd.last = word.last;
        cmd_push = accept && ua.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_char_reg   <= '0;
            run_count_reg  <= '0;
            varint_acc_reg <= '0;
            phase_reg      <= PH_CHAR;
            produced_reg   <= '0;
        end
        else if (accept)
        begin
            run_char_reg   <= run_char_next;
            run_count_reg  <= run_count_next;
            varint_acc_reg <= varint_acc_next;
            phase_reg      <= phase_next;
            produced_reg   <= produced_next;
        end
    end

endmodule

// ----- rtl/core/erlc_fifo.sv -----
// Command queue between front and back end.
`include "escape_run_length_codec_defines.svh"
module erlc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             not_empty,
    output logic             full
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    rd_ptr_reg, wr_ptr_reg;
    logic [AW:0]      count_reg;

    assign head_data = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == (AW+1)'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + (AW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (AW+1)'(1);
        end
    end

    `ERLC_NEVER(a_push_full, clk, rst_n, push && full, "word pushed into full queue")
    `ERLC_NEVER(a_pop_empty, clk, rst_n, pop && !not_empty, "pop from empty queue")
    `ERLC_ASSERT(a_empty_ptrs, clk, rst_n, (count_reg == '0) |-> (rd_ptr_reg == wr_ptr_reg), "queue pointers disagree with count")
endmodule

// ----- rtl/core/erlc_back.sv -----
// Back end: expands queued commands into output words, one per cycle unless the output stalls.
module erlc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  erlc_pkg::cfg_t      cfg,
    input  erlc_pkg::cmd_t      head,
    input  logic                head_valid,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output erlc_pkg::out_word_t out_word
);
    import erlc_pkg::*;

    logic                sel_reg, sel_next;
    logic [2:0]          step_reg, step_next;
    logic                out_valid_reg;
    out_word_t           out_word_reg, word;

    unit_t               u;
    logic [2:0]          ndig, dig;
    logic                escform, tail, unit_last, entry_last, fire;
    logic [6:0]          digit;

    always_comb
    begin
        u       = sel_reg ? head.b : head.a;
        ndig    = (u.rep[RUN_BITS-1:14] != '0) ? 3'd3 :
                  (u.rep[RUN_BITS-1:7] != '0) ? 3'd2 : 3'd1;
        escform = (u.rep >= RUN_BITS'(3)) || (u.byte_val == cfg.escape_code);
        tail    = (u.byte_val != cfg.escape_code) || (u.rep > RUN_BITS'(1));
        dig     = ndig - step_reg;
        case (dig[1:0])
            2'd0:    digit = u.rep[6:0];
            2'd1:    digit = u.rep[13:7];
            default: digit = u.rep[20:14];
        endcase
        word.out_byte   = u.byte_val;
        word.out_stream = STREAM_CHAR;
        word.repeat_res = RUN_BITS'(1);
        word.status     = ST_OK;
        if (!u.is_run)
        begin
            word.out_stream = u.stream;
            word.repeat_res = u.rep;
            word.status     = u.status;
            unit_last       = 1'b1;
        end
        else if (escform)
        begin
            if (step_reg == 3'd0)
            begin
                word.out_byte = cfg.escape_code;
            end
            else if (step_reg <= ndig)
            begin
                word.out_byte   = {step_reg != ndig, digit};
                word.out_stream = STREAM_RUN;
            end
            unit_last = (step_reg == ndig + {2'b00, tail});
        end
        else
        begin
            unit_last = (step_reg == u.rep[2:0] - 3'd1);
        end
        entry_last    = unit_last && (sel_reg || !head.b.valid);
        word.end_mark = head.last && entry_last;
        fire          = head_valid && (!out_valid_reg || out_ready);
        pop           = fire && entry_last;
        sel_next      = sel_reg;
        step_next     = step_reg;
        if (fire)
        begin
            if (entry_last)
            begin
                sel_next  = 1'b0;
                step_next = 3'd0;
            end
            else if (unit_last)
            begin
                sel_next  = 1'b1;
                step_next = 3'd0;
            end
            else
            begin
                step_next = step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg       <= 1'b0;
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg  <= sel_next;
            step_reg <= step_next;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            out_word_reg <= word;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- rtl/core/escape_run_length_codec.sv -----
// Escape run-length codec top level: config registers, front end, queue, back end.
// Usage:
//   req channel (req_valid/req_ready/req_word) takes one byte word per cycle while req_ready is high.
//   Encode (decode_mode 0): plain bytes in; coded words out on the character
//   stream (0) and the big-endian base-128 run count stream (1).
//   Decode (decode_mode 1): tagged coded bytes in; decoded byte plus repeat
//   count out, with status for limit, stream order and truncated block.
//   rsp channel (rsp_valid/rsp_ready/rsp_word) gives one result word a cycle while rsp_ready is high;
//   end_mark flags the last word caused by a word with last set.
//   Config writes (cfg_we, cfg_index, cfg_data) only while the codec is idle.
// Timing: the first result of a word passes through the command queue and the
//   output register. Input rate is one word per cycle while the command queue
//   has room; a word can expand to up to seven results, and the single output
//   register issues one result a cycle while rsp_ready is high, so bursts fill
//   the FIFO_DEPTH-entry queue.
// Reset: run, varint and limit state clear, queue empties, registers return
//   to encode mode, escape 255 and the full decode limit.
// When the receiver stalls the output word holds, the queue fills, and then
//   req_ready drops until space frees up.
module escape_run_length_codec #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  erlc_pkg::in_word_t               req_word,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output erlc_pkg::out_word_t              rsp_word,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [erlc_pkg::CFG_DW-1:0]      cfg_data
);
    import erlc_pkg::*;

    cfg_t   cfg_reg;
    cmd_t   push_cmd, head_cmd;
    logic   push, pop, head_valid, full, accept;

    assign req_ready = !full;
    assign accept    = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decode_mode   <= 1'b0;
            cfg_reg.escape_code   <= 8'hFF;
            cfg_reg.decoded_limit <= '1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:  cfg_reg.decode_mode   <= cfg_data[0];
                REG_ESC:   cfg_reg.escape_code   <= cfg_data[7:0];
                REG_LIMIT: cfg_reg.decoded_limit <= cfg_data[LIMIT_BITS-1:0];
                default:   ;
            endcase
        end
    end

    erlc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .word     (req_word),
        .accept   (accept),
        .cmd      (push_cmd),
        .cmd_push (push)
    );

    erlc_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_cmd),
        .pop       (pop),
        .head_data (head_cmd),
        .not_empty (head_valid),
        .full      (full)
    );

    erlc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (rsp_valid),
        .out_ready  (rsp_ready),
        .out_word   (rsp_word)
    );

endmodule

// ----- tb/escape_run_length_codec_test.sv -----
// Self-checking testbench of the escape run-length codec: encode and decode, with stalls.
module escape_run_length_codec_test;
    import erlc_pkg::*;

    localparam int MAX_IDLE = 4000;

    logic                   clk;
    logic                   rst_n;
    logic                   req_valid;
    logic                   req_ready;
    in_word_t               req_word;
    logic                   rsp_valid;
    logic                   rsp_ready;
    out_word_t              rsp_word;
    logic                   cfg_we;
    logic [1:0]             cfg_index;
    logic [CFG_DW-1:0]      cfg_data;

    escape_run_length_codec DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the codec state
    logic                  mode_m;
    logic [7:0]            esc_m;
    logic [LIMIT_BITS-1:0] limit_m;
    logic [7:0]            run_byte_m;
    logic [RUN_BITS-1:0]   run_len_m;
    logic [RUN_BITS-1:0]   count_acc_m;
    logic [1:0]            phase_m;
    logic [LIMIT_BITS-1:0] produced_m;

    in_word_t  pending_words[$];
    out_word_t expected_words[$];
    int        sent_count;
    int        got_count;
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_cycles;
    int        quiet_cycles;
    int        enc_items;
    int        dec_items;
    int        error_words;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic push_word(input logic [7:0] b, input logic [1:0] s,
                             input logic [RUN_BITS-1:0] r, input logic [1:0] st);
        out_word_t w;
        w.out_byte   = b;
        w.out_stream = s;
        w.repeat_res = r;
        w.status     = st;
        w.end_mark   = 1'b0;
        expected_words.push_back(w);
    endtask

    task automatic flush_open_run();
        int k;
        logic [7:0] vb;
        if (run_len_m == 0)
            return;
        if (run_len_m >= 3 || run_byte_m == esc_m)
        begin
            push_word(esc_m, STREAM_CHAR, 1, ST_OK);
            k = 1;
            while (k < 5 && (run_len_m >> (7 * k)) != 0)
                k++;
            for (int i = k; i > 0; i--)
            begin
                vb = 8'((run_len_m >> (7 * (i - 1))) & 8'h7f);
                if (i > 1)
                    vb[7] = 1'b1;
                push_word(vb, STREAM_RUN, 1, ST_OK);
            end
            if (run_byte_m != esc_m || run_len_m > 1)
                push_word(run_byte_m, STREAM_CHAR, 1, ST_OK);
        end
        else
        begin
            for (int j = 0; j < run_len_m; j++)
                push_word(run_byte_m, STREAM_CHAR, 1, ST_OK);
        end
        run_len_m = 0;
    endtask

    task automatic give_decoded(input logic [7:0] b, input logic [RUN_BITS-1:0] r);
        if (40'(produced_m) + 40'(r) > 40'(limit_m))
            push_word(b, STREAM_DATA, 0, ST_LIMIT);
        else
        begin
            produced_m = produced_m + LIMIT_BITS'(r);
            push_word(b, STREAM_DATA, r, ST_OK);
        end
    endtask

    task automatic decode_one(input logic [7:0] b, input logic sel);
        if (phase_m == 1)
        begin
            if (!sel)
            begin
                push_word(0, STREAM_DATA, 0, ST_ORDER);
                return;
            end
            if (count_acc_m > (RUN_MAX >> 7))
                count_acc_m = RUN_MAX;
            else
                count_acc_m = (count_acc_m << 7) | RUN_BITS'(b[6:0]);
            if (b[7])
                return;
            if (count_acc_m == 1)
            begin
                give_decoded(esc_m, 1);
                count_acc_m = 0;
                phase_m = 0;
            end
            else
                phase_m = 2;
        end
        else if (phase_m == 2)
        begin
            if (sel)
            begin
                push_word(0, STREAM_DATA, 0, ST_ORDER);
                return;
            end
            if (count_acc_m != 0)
                give_decoded(b, count_acc_m);
            count_acc_m = 0;
            phase_m = 0;
        end
        else
        begin
            if (sel)
            begin
                push_word(0, STREAM_DATA, 0, ST_ORDER);
                return;
            end
            if (b == esc_m)
            begin
                count_acc_m = 0;
                phase_m = 1;
            end
            else
                give_decoded(b, 1);
        end
    endtask

    // work out the results of one accepted word
    task automatic predict_codec(input in_word_t w);
        int n0;
        n0 = expected_words.size();
        if (!mode_m)
        begin
            enc_items++;
            if (run_len_m != 0 && w.in_byte == run_byte_m && run_len_m < RUN_MAX)
                run_len_m++;
            else
            begin
                flush_open_run();
                run_byte_m = w.in_byte;
                run_len_m = 1;
            end
            if (w.last)
                flush_open_run();
        end
        else
        begin
            dec_items++;
            decode_one(w.in_byte, w.stream_sel);
            if (w.last)
            begin
                if (phase_m != 0)
                    push_word(0, STREAM_DATA, 0, ST_TRUNC);
                phase_m = 0;
                count_acc_m = 0;
                produced_m = 0;
            end
        end
        if (w.last && expected_words.size() > n0)
            expected_words[expected_words.size() - 1].end_mark = 1'b1;
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_word  <= '0;
        end
        else if (!req_valid || req_ready)
        begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req_valid <= 1'b1;
                req_word  <= pending_words.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // receiver ready and watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready    <= 1'b0;
            quiet_cycles <= 0;
        end
        else
        begin
            if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                rsp_ready   <= 1'b0;
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= MAX_IDLE)
            begin
                $display("timeout: %0d words still expected", expected_words.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && req_valid && req_ready)
        begin
            predict_codec(req_word);
            sent_count <= sent_count + 1;
        end
        if (rst_n && rsp_valid && rsp_ready)
        begin
            got_count <= got_count + 1;
            if (rsp_word.status != ST_OK)
                error_words <= error_words + 1;
            if (expected_words.size() == 0)
            begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("unexpected result word %p", rsp_word);
            end
            else if (rsp_word !== expected_words[0])
            begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10)
                    $display("word mismatch: expected %p got %p",
                             expected_words[0], rsp_word);
                void'(expected_words.pop_front());
            end
            else
                void'(expected_words.pop_front());
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_MODE)
            mode_m = val[0];
        else if (idx == REG_ESC)
            esc_m = val[7:0];
        else
            limit_m = val[LIMIT_BITS-1:0];
    endtask

    task automatic add_word(input logic [7:0] b, input logic s, input logic l);
        in_word_t w;
        w.in_byte    = b;
        w.stream_sel = s;
        w.last       = l;
        pending_words.push_back(w);
    endtask

    // wait for every queued word to go in and every result to come out
    task automatic drain();
        while (pending_words.size() > 0 || req_valid || expected_words.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // random encoder block: runs of random length, sometimes the escape byte
    task automatic add_enc_block(input int runs);
        logic [7:0] b;
        int len;
        for (int i = 0; i < runs; i++)
        begin
            case ($urandom_range(3))
                0: b = esc_m;
                1: b = 8'($urandom_range(3));
                default: b = 8'($urandom_range(255));
            endcase
            len = ($urandom_range(3) == 0) ? $urandom_range(12) + 1 : $urandom_range(3) + 1;
            for (int j = 0; j < len; j++)
                add_word(b, $urandom_range(1), (i == runs - 1) && (j == len - 1));
        end
    endtask

    // random decoder block: mostly well formed tokens, some noise
    task automatic add_dec_block(input int toks);
        logic [7:0] b;
        int cnt;
        int k;
        for (int i = 0; i < toks; i++)
        begin
            case ($urandom_range(9))
                0, 1, 2:
                begin
                    b = 8'($urandom_range(255));
                    if (b == esc_m)
                        b = b + 8'd1;
                    add_word(b, 1'b0, 1'b0);
                end
                3, 4, 5, 6:
                begin
                    case ($urandom_range(4))
                        0: cnt = $urandom_range(1);
                        1: cnt = $urandom_range(127);
                        2: cnt = $urandom_range(16383);
                        3: cnt = $urandom_range(RUN_MAX);
                        default: cnt = $urandom;
                    endcase
                    add_word(esc_m, 1'b0, 1'b0);
                    k = 1;
                    while (k < 5 && (cnt >> (7 * k)) != 0)
                        k++;
                    for (int m = k; m > 0; m--)
                        add_word(8'((cnt >> (7 * (m - 1))) & 127) | ((m > 1) ? 8'h80 : 8'h00),
                                 1'b1, 1'b0);
                    if (cnt != 1)
                        add_word(8'($urandom_range(255)), 1'b0, 1'b0);
                end
                default: add_word(8'($urandom_range(255)), $urandom_range(1), 1'b0);
            endcase
        end
        pending_words[pending_words.size() - 1].last = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MODE;
        cfg_data = '0;
        mode_m = 1'b0;
        esc_m = 8'hff;
        limit_m = '1;
        run_byte_m = '0;
        run_len_m = '0;
        count_acc_m = '0;
        phase_m = '0;
        produced_m = '0;
        sent_count = 0;
        got_count = 0;
        mismatch_count = 0;
        hold_cycles = 0;
        enc_items = 0;
        dec_items = 0;
        error_words = 0;
        send_idle_pct = 22;
        recv_idle_pct = 46;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed encoder: literals, runs, lone escape, escape run, extremes
        write_reg(REG_MODE, 0);
        write_reg(REG_ESC, 255);
        add_word(8'h00, 0, 0);
        add_word(8'h00, 1, 0);
        add_word(8'hff, 0, 0);
        add_word(8'h41, 0, 0);
        for (int i = 0; i < 5; i++)
            add_word(8'h41, 0, 0);
        add_word(8'hff, 0, 0);
        add_word(8'hff, 0, 0);
        add_word(8'h80, 0, 1);
        drain();

        // directed decoder: counts 0, 1, multi byte, misorder, limit, truncation
        write_reg(REG_MODE, 1);
        write_reg(REG_LIMIT, 10);
        add_word(8'h12, 0, 0);
        add_word(8'h05, 1, 0);
        add_word(8'hff, 0, 0);
        add_word(8'h01, 1, 0);
        add_word(8'hff, 0, 0);
        add_word(8'h00, 1, 0);
        add_word(8'h33, 0, 0);
        add_word(8'hff, 0, 0);
        add_word(8'h00, 0, 0);
        add_word(8'h81, 1, 0);
        add_word(8'h00, 1, 0);
        add_word(8'h44, 0, 0);
        add_word(8'hff, 0, 0);
        add_word(8'hff, 1, 0);
        add_word(8'hff, 1, 0);
        add_word(8'hff, 1, 0);
        add_word(8'h7f, 1, 0);
        add_word(8'h55, 0, 0);
        add_word(8'hff, 0, 0);
        add_word(8'h83, 1, 1);
        drain();

        // long encoder run with escape 0: two-byte varint count
        write_reg(REG_MODE, 0);
        write_reg(REG_ESC, 0);
        for (int i = 0; i < 130; i++)
            add_word(8'h07, 0, i == 129);
        drain();

        // random phases over several settings
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 22;
            end
            if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(REG_MODE, ph % 2);
            write_reg(REG_ESC, (ph % 3 == 0) ? 8'hff : ((ph % 3 == 1) ? 8'h00
                                                      : 8'($urandom_range(255))));
            case (ph % 4)
                0: write_reg(REG_LIMIT, '1);
                1: write_reg(REG_LIMIT, 0);
                2: write_reg(REG_LIMIT, $urandom_range(3000));
                default: write_reg(REG_LIMIT, $urandom_range(24'hffffff));
            endcase
            if (ph == 5)
                hold_cycles = 60;
            for (int blk = 0; blk < 2; blk++)
            begin
                if (ph % 2)
                    add_dec_block($urandom_range(4) + 4);
                else
                    add_enc_block($urandom_range(4) + 3);
            end
            drain();
        end

        $display("covered %0d encoder and %0d decoder words, %0d results, %0d error results",
                 enc_items, dec_items, got_count, error_words);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/erlc_pkg.sv
rtl/core/erlc_front.sv
rtl/core/erlc_fifo.sv
rtl/core/erlc_back.sv
rtl/core/escape_run_length_codec.sv
tb/escape_run_length_codec_test.sv
